>>> rtl/vst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vst_pkg;

    localparam int CELLS_DEF  = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;
    localparam int SIZE_W     = 5;
    localparam int COORD_W    = 8;
    localparam int OCC_W      = 16;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
    localparam logic [OCC_W-1:0]  HALF_Q15   = 16'd16384;

    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        CLASS_BELOW,
        CLASS_HALF,
        CLASS_ABOVE
    } class_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } grid_ctl_t;

    function automatic class_t class_of(input logic [OCC_W-1:0] occ);
        class_t c;
        if (occ < HALF_Q15)
        begin
            c = CLASS_BELOW;
        end
        else if (occ == HALF_Q15)
        begin
            c = CLASS_HALF;
        end
        else
        begin
            c = CLASS_ABOVE;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/vst_grid.sv
`timescale 1ns / 1ps
`default_nettype none

module vst_grid #(
    parameter int ADDR_W = 12
) (
    input  wire                logic             clk,
    input  wire                logic             rst_n,
    input  vst_pkg::grid_ctl_t                   ctl,
    input  wire                logic [ADDR_W-1:0] addr,
    input  vst_pkg::class_t                      wdata,
    output vst_pkg::class_t                      rdata,
    output logic                                 busy
);
    import vst_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    class_t            mem [DEPTH];
    class_t            rdata_reg;
    logic              busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

    // sweep the whole array to the below-half class after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (&clr_addr_reg)
            begin
                busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= CLASS_BELOW;
        end
        else if (ctl.wr)
        begin
            mem[addr] <= wdata;
        end
        else if (ctl.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    a_ctl_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.rd && ctl.wr))
        else $error("grid read and write requested together");

    a_busy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !(ctl.rd || ctl.wr))
        else $error("grid access during clearing sweep");

    a_busy_once: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |=> !busy_reg)
        else $error("clearing sweep restarted");

endmodule

`default_nettype wire

>>> rtl/voxel_surface_test_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Voxel grid of CELLS_PER_AXIS^3 cells, each holding an occupancy class (below, exactly
// or above one half, Q1.15 input). A write item (tuser 0) stores one cell's class; a query
// item (tuser 1) reports whether the index is inside the configured grid and whether any
// of its up to 26 neighbours, clamped to the grid edges, holds a different class. Every
// item gives exactly one result. After reset a clearing pass sets every cell of the memory
// to the below-half class before the first item is taken; configuration writes are
// taken at any time. All cells sit in one single-port memory with one access per cycle.
// An out-of-range item goes straight to its result; a write stores its cell; a query reads
// its own cell and then every cell of its clamped box (1 to 27 cells). Items are handled
// one at a time, but the next item is taken while a result still waits on the output.
module voxel_surface_test_unit #(
    parameter int CELLS_PER_AXIS = vst_pkg::CELLS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // x_coord[7:0], y_coord[15:8], z_coord[23:16], occupancy[39:24]
    input  wire logic [vst_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // cmd[0]
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // valid_index[0], is_surface[1], zero[7:2]
    output logic [vst_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [vst_pkg::SIZE_W-1:0]      cfg_data
);
    import vst_pkg::*;

    localparam int AW     = $clog2(CELLS_PER_AXIS);
    localparam int ADDR_W = 3 * AW;
    localparam logic [COORD_W-1:0] N8 = COORD_W'(CELLS_PER_AXIS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_CENTER,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [SIZE_W-1:0] size_x_reg;
    logic [SIZE_W-1:0] size_y_reg;
    logic [SIZE_W-1:0] size_z_reg;

    logic              cmd_reg;
    logic              vidx_reg;
    class_t            class_reg;
    class_t            own_reg;
    logic              surf_reg;
    logic [AW-1:0]     x_reg, y_reg, z_reg;
    logic [AW-1:0]     xlo_reg, ylo_reg, zlo_reg;
    logic [AW-1:0]     xhi_reg, yhi_reg, zhi_reg;
    logic [AW-1:0]     i_reg, j_reg, k_reg;
    logic              rd_vld_reg;
    logic              rd_center_reg;
    logic              rd_cmp_reg;
    logic              out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [COORD_W-1:0] in_x, in_y, in_z;
    logic [OCC_W-1:0]   in_occ;
    logic [COORD_W-1:0] nx, ny, nz;
    logic               in_valid_idx;
    logic               in_accept;
    logic               scan_last;
    logic               grid_busy;
    grid_ctl_t          grid_ctl;
    logic [ADDR_W-1:0]  grid_addr;
    class_t             grid_rdata;

    assign in_x   = s_axis_tdata[7:0];
    assign in_y   = s_axis_tdata[15:8];
    assign in_z   = s_axis_tdata[23:16];
    assign in_occ = s_axis_tdata[39:24];

    assign nx = ({3'b000, size_x_reg} > N8) ? N8 : {3'b000, size_x_reg};
    assign ny = ({3'b000, size_y_reg} > N8) ? N8 : {3'b000, size_y_reg};
    assign nz = ({3'b000, size_z_reg} > N8) ? N8 : {3'b000, size_z_reg};

    assign in_valid_idx = (in_x < nx) && (in_y < ny) && (in_z < nz);

    assign s_axis_tready = (state_reg == ST_IDLE) && !grid_busy;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign scan_last = (i_reg == xhi_reg) && (j_reg == yhi_reg) && (k_reg == zhi_reg);

    function automatic logic [AW-1:0] lower_edge(input logic [COORD_W-1:0] c);
        return (c != '0) ? AW'(c - 1'b1) : '0;
    endfunction

    function automatic logic [AW-1:0] upper_edge(input logic [COORD_W-1:0] c,
                                                 input logic [COORD_W-1:0] n);
        return ((c + 1'b1) < n) ? AW'(c + 1'b1) : AW'(n - 1'b1);
    endfunction

    always_comb
    begin
        grid_ctl  = '0;
        grid_addr = {i_reg, j_reg, k_reg};
        case (state_reg)
            ST_WRITE:
            begin
                grid_ctl.wr = 1'b1;
                grid_addr   = {x_reg, y_reg, z_reg};
            end
            ST_CENTER:
            begin
                grid_ctl.rd = 1'b1;
                grid_addr   = {x_reg, y_reg, z_reg};
            end
            ST_SCAN:
            begin
                grid_ctl.rd = 1'b1;
            end
            default:
            begin
                grid_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_RESET;
            size_y_reg <= SIZE_RESET;
            size_z_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SIZE_X: size_x_reg <= cfg_data;
                REG_SIZE_Y: size_y_reg <= cfg_data;
                REG_SIZE_Z: size_z_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= CMD_WRITE;
            vidx_reg      <= 1'b0;
            class_reg     <= CLASS_BELOW;
            own_reg       <= CLASS_BELOW;
            surf_reg      <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            xlo_reg       <= '0;
            ylo_reg       <= '0;
            zlo_reg       <= '0;
            xhi_reg       <= '0;
            yhi_reg       <= '0;
            zhi_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            rd_center_reg <= 1'b0;
            rd_cmp_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            rd_vld_reg <= 1'b0;

            // consume read data in the cycle after the request
            if (rd_vld_reg)
            begin
                if (rd_center_reg)
                begin
                    own_reg <= grid_rdata;
                end
                else if (rd_cmp_reg && (grid_rdata != own_reg))
                begin
                    surf_reg <= 1'b1;
                end
            end

            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        cmd_reg   <= s_axis_tuser;
                        vidx_reg  <= in_valid_idx;
                        class_reg <= class_of(in_occ);
                        surf_reg  <= 1'b0;
                        x_reg     <= AW'(in_x);
                        y_reg     <= AW'(in_y);
                        z_reg     <= AW'(in_z);
                        xlo_reg   <= lower_edge(in_x);
                        ylo_reg   <= lower_edge(in_y);
                        zlo_reg   <= lower_edge(in_z);
                        xhi_reg   <= upper_edge(in_x, nx);
                        yhi_reg   <= upper_edge(in_y, ny);
                        zhi_reg   <= upper_edge(in_z, nz);
                        if (!in_valid_idx)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else if (s_axis_tuser == CMD_WRITE)
                        begin
                            state_reg <= ST_WRITE;
                        end
                        else
                        begin
                            state_reg <= ST_CENTER;
                        end
                    end
                end
                ST_WRITE:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_CENTER:
                begin
                    i_reg         <= xlo_reg;
                    j_reg         <= ylo_reg;
                    k_reg         <= zlo_reg;
                    rd_vld_reg    <= 1'b1;
                    rd_center_reg <= 1'b1;
                    state_reg     <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    rd_vld_reg    <= 1'b1;
                    rd_center_reg <= 1'b0;
                    rd_cmp_reg    <= !((i_reg == x_reg) && (j_reg == y_reg)
                                       && (k_reg == z_reg));
                    if (k_reg != zhi_reg)
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                    else
                    begin
                        k_reg <= zlo_reg;
                        if (j_reg != yhi_reg)
                        begin
                            j_reg <= j_reg + 1'b1;
                        end
                        else
                        begin
                            j_reg <= ylo_reg;
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                    if (scan_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {6'b000000,
                                          surf_reg && vidx_reg && (cmd_reg == CMD_QUERY),
                                          vidx_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    vst_grid #(
        .ADDR_W (ADDR_W)
    ) u_grid (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (grid_ctl),
        .addr  (grid_addr),
        .wdata (class_reg),
        .rdata (grid_rdata),
        .busy  (grid_busy)
    );

    a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        grid_busy |-> !s_axis_tready)
        else $error("item taken during clearing sweep");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("second item taken before first finished");

    a_surf_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[0])
        else $error("surface reported for out-of-range index");

endmodule

`default_nettype wire
